// ===== hw/rtl/pwc_pkg.sv =====
// Shared types, constants and helper functions for the pileup window counter.
// Used by pwc_decode and pileup_window_counter; no dependencies.
`default_nettype none

package pwc_pkg;

    localparam int WINDOW      = 1024;
    localparam int COUNT_BITS  = 32;

    localparam int OFS_W       = 10;
    localparam int CODE_W      = 4;
    localparam int POS_W       = 31;
    localparam int OUT_W       = 32;
    localparam int GRP_W       = 5;
    localparam int COL_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int BA_W        = COL_W + 2;
    localparam int CA_W        = COL_W + 4;
    localparam int BASE_DEPTH  = WINDOW * 4;
    localparam int CODON_DEPTH = WINDOW * 16;
    localparam int ROW_W       = 4 * COUNT_BITS;
    localparam int SUM_W       = ((COL_W > OFS_W) ? COL_W : OFS_W) + 1;
    localparam int RED_STEPS   = (WINDOW >= (1 << OFS_W)) ? 1
                                 : $clog2((1 << OFS_W) / WINDOW) + 1;

    // Rows of one column in the strand/gap memory
    localparam logic [1:0] ROW_FWD = 2'd0;
    localparam logic [1:0] ROW_REV = 2'd1;
    localparam logic [1:0] ROW_GAP = 2'd2;

    localparam logic [GRP_W-1:0] GRP_FIRST_CODON = GRP_W'(3);
    localparam logic [GRP_W-1:0] GRP_LAST        = GRP_W'(18);

    typedef enum logic [1:0] {
        CMD_ADVANCE = 2'd0,
        CMD_BASE    = 2'd1,
        CMD_GAP     = 2'd2,
        CMD_SETPOS  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT,
        ST_DRAIN
    } state_t;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef count_t [3:0] row_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] idx;
    } base_t;

    typedef struct packed {
        logic            base_en;
        logic [BA_W-1:0] base_row;
        logic [1:0]      base_lane;
        logic            codon_en;
        logic [CA_W-1:0] codon_row;
        logic [1:0]      codon_lane;
    } item_t;

    // One-hot sequence code to A/C/G/T index; everything else is ambiguous
    function automatic base_t code_to_base(input logic [CODE_W-1:0] code);
        base_t b;
        b = '0;
        unique case (code)
            4'h1:    b = '{valid: 1'b1, idx: 2'd0};
            4'h2:    b = '{valid: 1'b1, idx: 2'd1};
            4'h4:    b = '{valid: 1'b1, idx: 2'd2};
            4'h8:    b = '{valid: 1'b1, idx: 2'd3};
            default: b = '0;
        endcase
        return b;
    endfunction

    // offset mod WINDOW by restoring subtraction of shifted window sizes
    function automatic logic [OFS_W-1:0] reduce_offset(input logic [OFS_W-1:0] ofs);
        logic [OFS_W-1:0] r;
        r = ofs;
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (int'(r) >= (WINDOW << k))
            begin
                r = r - OFS_W'(WINDOW << k);
            end
        end
        return r;
    endfunction

    function automatic count_t sat_inc(input count_t c);
        return (&c) ? c : c + count_t'(1);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input count_t c);
        logic [63:0] w;
        w = 64'(c);
        return w[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pileup_window_counter.sv =====
// Pileup window counter: per-column base, gap and codon counts over a circular
// window of reference columns, stored in two count memories (strand/gap rows and
// codon rows, four saturating counters per row). An aligned-base or deletion word
// takes a read and then a write-back of the row it bumps; a set-position word only
// loads the head position. An advance word streams the head column as 19 groups at
// one group per cycle while the output side keeps up, clearing each row as it is
// read. After reset a clearing pass over all WINDOW*16 codon rows (16384 at the
// default window) zeroes both memories before the first word is taken.
// Depends on pwc_pkg, pwc_decode and pwc_ram.
`default_nettype none

module pileup_window_counter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  command,
    input  wire logic [pwc_pkg::OFS_W-1:0]   offset,
    input  wire logic                        reverse_strand,
    input  wire logic [pwc_pkg::CODE_W-1:0]  base_code,
    input  wire logic [pwc_pkg::CODE_W-1:0]  next_code_one,
    input  wire logic [pwc_pkg::CODE_W-1:0]  next_code_two,
    input  wire logic                        codon_allowed,
    input  wire logic [pwc_pkg::POS_W-1:0]   new_position,

    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [pwc_pkg::OUT_W-1:0]        column_position,
    output logic [pwc_pkg::GRP_W-1:0]        group,
    output logic [pwc_pkg::OUT_W-1:0]        count_zero,
    output logic [pwc_pkg::OUT_W-1:0]        count_one,
    output logic [pwc_pkg::OUT_W-1:0]        count_two,
    output logic [pwc_pkg::OUT_W-1:0]        count_three,
    output logic                             last
);

    pwc_pkg::state_t               state_reg, state_next;
    logic [pwc_pkg::CA_W-1:0]      clr_reg, clr_next;
    logic [pwc_pkg::COL_W-1:0]     head_slot_reg, head_slot_next;
    logic [pwc_pkg::POS_W-1:0]     head_pos_reg, head_pos_next;
    pwc_pkg::item_t                item_reg, item_next;
    logic [pwc_pkg::GRP_W-1:0]     grp_reg, grp_next;
    logic                          pend_reg, pend_next;
    logic [pwc_pkg::GRP_W-1:0]     pend_grp_reg, pend_grp_next;
    logic                          out_valid_reg, out_valid_next;
    logic [pwc_pkg::OUT_W-1:0]     out_pos_reg, out_pos_next;
    logic [pwc_pkg::GRP_W-1:0]     out_grp_reg, out_grp_next;
    pwc_pkg::row_t                 out_row_reg, out_row_next;
    logic                          out_last_reg, out_last_next;

    logic                          b_wr_en, b_rd_en;
    logic [pwc_pkg::BA_W-1:0]      b_wr_addr, b_rd_addr;
    pwc_pkg::row_t                 b_wr_data, b_rd_data;
    logic                          c_wr_en, c_rd_en;
    logic [pwc_pkg::CA_W-1:0]      c_wr_addr, c_rd_addr;
    pwc_pkg::row_t                 c_wr_data, c_rd_data;

    pwc_pkg::item_t                dec_item;
    pwc_pkg::cmd_t                 cmd;
    logic                          accept;
    logic                          load;
    logic                          issue;
    logic                          drained;
    logic [pwc_pkg::GRP_W-1:0]     codon_grp;

    pwc_decode u_decode (
        .command        (command),
        .offset         (offset),
        .reverse_strand (reverse_strand),
        .base_code      (base_code),
        .next_code_one  (next_code_one),
        .next_code_two  (next_code_two),
        .codon_allowed  (codon_allowed),
        .head_slot      (head_slot_reg),
        .item           (dec_item)
    );

    pwc_ram #(
        .WIDTH (pwc_pkg::ROW_W),
        .DEPTH (pwc_pkg::BASE_DEPTH)
    ) u_base_ram (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (b_wr_data),
        .rd_en   (b_rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    pwc_ram #(
        .WIDTH (pwc_pkg::ROW_W),
        .DEPTH (pwc_pkg::CODON_DEPTH)
    ) u_codon_ram (
        .clk     (clk),
        .wr_en   (c_wr_en),
        .wr_addr (c_wr_addr),
        .wr_data (c_wr_data),
        .rd_en   (c_rd_en),
        .rd_addr (c_rd_addr),
        .rd_data (c_rd_data)
    );

    assign cmd       = pwc_pkg::cmd_t'(command);
    assign accept    = in_valid && in_ready;
    // RAM read register doubles as the skid stage in front of the output register
    assign load      = pend_reg && (!out_valid_reg || out_ready);
    assign drained   = !pend_reg || load;
    assign codon_grp = grp_reg - pwc_pkg::GRP_FIRST_CODON;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pwc_pkg::ST_CLEAR:
            begin
                if (clr_reg == pwc_pkg::CA_W'(pwc_pkg::CODON_DEPTH - 1))
                begin
                    state_next = pwc_pkg::ST_IDLE;
                end
            end
            pwc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd) inside
                        pwc_pkg::CMD_ADVANCE:               state_next = pwc_pkg::ST_EMIT;
                        pwc_pkg::CMD_BASE, pwc_pkg::CMD_GAP: state_next = pwc_pkg::ST_UPDATE;
                        default:                            state_next = pwc_pkg::ST_IDLE;
                    endcase
                end
            end
            pwc_pkg::ST_UPDATE: state_next = pwc_pkg::ST_IDLE;
            pwc_pkg::ST_EMIT:
            begin
                if (issue && grp_reg == pwc_pkg::GRP_LAST)
                begin
                    state_next = pwc_pkg::ST_DRAIN;
                end
            end
            pwc_pkg::ST_DRAIN:
            begin
                if (drained)
                begin
                    state_next = pwc_pkg::ST_IDLE;
                end
            end
            default: state_next = pwc_pkg::ST_IDLE;
        endcase
    end

    // memory control and state-dependent datapath
    always_comb
    begin
        pwc_pkg::row_t b_mod;
        pwc_pkg::row_t c_mod;

        b_mod          = b_rd_data;
        c_mod          = c_rd_data;
        in_ready       = 1'b0;
        issue          = 1'b0;
        b_wr_en        = 1'b0;
        b_wr_addr      = item_reg.base_row;
        b_wr_data      = '0;
        b_rd_en        = 1'b0;
        b_rd_addr      = dec_item.base_row;
        c_wr_en        = 1'b0;
        c_wr_addr      = item_reg.codon_row;
        c_wr_data      = '0;
        c_rd_en        = 1'b0;
        c_rd_addr      = dec_item.codon_row;
        clr_next       = clr_reg;
        head_slot_next = head_slot_reg;
        head_pos_next  = head_pos_reg;
        item_next      = item_reg;
        grp_next       = grp_reg;

        unique case (state_reg)
            pwc_pkg::ST_CLEAR:
            begin
                c_wr_en   = 1'b1;
                c_wr_addr = clr_reg;
                b_wr_en   = (clr_reg < pwc_pkg::CA_W'(pwc_pkg::BASE_DEPTH));
                b_wr_addr = clr_reg[pwc_pkg::BA_W-1:0];
                clr_next  = clr_reg + pwc_pkg::CA_W'(1);
            end
            pwc_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                b_rd_en   = accept && dec_item.base_en;
                c_rd_en   = accept && dec_item.codon_en;
                if (accept)
                begin
                    item_next = dec_item;
                    grp_next  = '0;
                    if (cmd == pwc_pkg::CMD_SETPOS)
                    begin
                        head_pos_next = new_position;
                    end
                end
            end
            pwc_pkg::ST_UPDATE:
            begin
                b_mod[item_reg.base_lane]  = pwc_pkg::sat_inc(b_rd_data[item_reg.base_lane]);
                c_mod[item_reg.codon_lane] = pwc_pkg::sat_inc(c_rd_data[item_reg.codon_lane]);
                b_wr_en   = item_reg.base_en;
                b_wr_data = b_mod;
                c_wr_en   = item_reg.codon_en;
                c_wr_data = c_mod;
            end
            pwc_pkg::ST_EMIT:
            begin
                issue = drained;
                // read each head row and zero it in the same cycle (read returns old data)
                if (grp_reg < pwc_pkg::GRP_FIRST_CODON)
                begin
                    b_rd_en   = issue;
                    b_rd_addr = {head_slot_reg, grp_reg[1:0]};
                    b_wr_en   = issue;
                    b_wr_addr = {head_slot_reg, grp_reg[1:0]};
                end
                else
                begin
                    c_rd_en   = issue;
                    c_rd_addr = {head_slot_reg, codon_grp[3:0]};
                    c_wr_en   = issue;
                    c_wr_addr = {head_slot_reg, codon_grp[3:0]};
                end
                if (issue)
                begin
                    grp_next = grp_reg + pwc_pkg::GRP_W'(1);
                end
            end
            pwc_pkg::ST_DRAIN:
            begin
                // head moves only once the last group has left the RAM stage
                if (drained)
                begin
                    head_slot_next = (head_slot_reg == pwc_pkg::COL_W'(pwc_pkg::WINDOW - 1))
                                     ? '0 : head_slot_reg + pwc_pkg::COL_W'(1);
                    head_pos_next  = head_pos_reg + pwc_pkg::POS_W'(1);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // read stage and output register
    always_comb
    begin
        pend_next      = issue ? 1'b1 : (load ? 1'b0 : pend_reg);
        pend_grp_next  = issue ? grp_reg : pend_grp_reg;
        out_valid_next = load || (out_valid_reg && !out_ready);
        out_pos_next   = out_pos_reg;
        out_grp_next   = out_grp_reg;
        out_row_next   = out_row_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_pos_next  = pwc_pkg::OUT_W'(head_pos_reg) + pwc_pkg::OUT_W'(1);
            out_grp_next  = pend_grp_reg;
            out_row_next  = (pend_grp_reg >= pwc_pkg::GRP_FIRST_CODON) ? c_rd_data : b_rd_data;
            out_last_next = (pend_grp_reg == pwc_pkg::GRP_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwc_pkg::ST_CLEAR;
            clr_reg       <= '0;
            head_slot_reg <= '0;
            head_pos_reg  <= '0;
            grp_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_slot_reg <= head_slot_next;
            head_pos_reg  <= head_pos_next;
            grp_reg       <= grp_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pend_grp_reg <= pend_grp_next;
        out_pos_reg  <= out_pos_next;
        out_grp_reg  <= out_grp_next;
        out_row_reg  <= out_row_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign column_position = out_pos_reg;
    assign group           = out_grp_reg;
    assign count_zero      = pwc_pkg::to_out(out_row_reg[0]);
    assign count_one       = pwc_pkg::to_out(out_row_reg[1]);
    assign count_two       = pwc_pkg::to_out(out_row_reg[2]);
    assign count_three     = pwc_pkg::to_out(out_row_reg[3]);
    assign last            = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pwc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read of an address written in the same cycle returns the old data.
`default_nettype none

module pwc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pwc_decode.sv =====
// Item decoder: maps sequence codes and the window offset to memory rows and lanes.
// Depends on pwc_pkg.
`default_nettype none

module pwc_decode (
    input  wire logic [1:0]                  command,
    input  wire logic [pwc_pkg::OFS_W-1:0]   offset,
    input  wire logic                        reverse_strand,
    input  wire logic [pwc_pkg::CODE_W-1:0]  base_code,
    input  wire logic [pwc_pkg::CODE_W-1:0]  next_code_one,
    input  wire logic [pwc_pkg::CODE_W-1:0]  next_code_two,
    input  wire logic                        codon_allowed,
    input  wire logic [pwc_pkg::COL_W-1:0]   head_slot,
    output pwc_pkg::item_t                   item
);

    pwc_pkg::cmd_t                 cmd;
    pwc_pkg::base_t                b0;
    pwc_pkg::base_t                b1;
    pwc_pkg::base_t                b2;
    logic [pwc_pkg::OFS_W-1:0]     ofs_red;
    logic [pwc_pkg::SUM_W-1:0]     sum;
    logic [pwc_pkg::SUM_W-1:0]     sum_wrap;
    logic [pwc_pkg::COL_W-1:0]     col;
    logic                          is_base;
    logic                          is_gap;

    assign cmd     = pwc_pkg::cmd_t'(command);
    assign b0      = pwc_pkg::code_to_base(base_code);
    assign b1      = pwc_pkg::code_to_base(next_code_one);
    assign b2      = pwc_pkg::code_to_base(next_code_two);
    assign is_base = (cmd == pwc_pkg::CMD_BASE);
    assign is_gap  = (cmd == pwc_pkg::CMD_GAP);

    // column = (head + offset) mod WINDOW
    assign ofs_red  = pwc_pkg::reduce_offset(offset);
    assign sum      = pwc_pkg::SUM_W'(head_slot) + pwc_pkg::SUM_W'(ofs_red);
    assign sum_wrap = (sum >= pwc_pkg::SUM_W'(pwc_pkg::WINDOW))
                      ? sum - pwc_pkg::SUM_W'(pwc_pkg::WINDOW) : sum;
    assign col      = sum_wrap[pwc_pkg::COL_W-1:0];

    always_comb
    begin
        item.base_en    = (is_base && b0.valid) || is_gap;
        item.base_row   = {col, is_gap ? pwc_pkg::ROW_GAP
                                       : (reverse_strand ? pwc_pkg::ROW_REV
                                                         : pwc_pkg::ROW_FWD)};
        item.base_lane  = is_gap ? 2'd0 : b0.idx;
        item.codon_en   = is_base && codon_allowed && b0.valid && b1.valid && b2.valid;
        // codon index 16*b0 + 4*b1 + b2: row picks four codons, lane picks one
        item.codon_row  = {col, b0.idx, b1.idx};
        item.codon_lane = b2.idx;
    end

endmodule

`default_nettype wire

// ===== bench/tb_pileup_window_counter.sv =====
// Self-checking bench for pileup_window_counter: a directed table, then read-like runs
// with random content, scored by a column predictor (typed table columns are written by hand).
// Depends on pwc_pkg and the pileup_window_counter RTL.
`timescale 1ns / 100ps

module tb_pileup_window_counter;

    import pwc_pkg::*;

    localparam int GAP_GROUP     = 2;
    localparam int COLUMN_GROUPS = int'(GRP_LAST) + 1;
    localparam int CODON_SLOTS   = 64;
    localparam int RANDOM_WORDS  = 200;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        cmd_t                cmd;
        logic [OFS_W-1:0]    ofs;
        logic                rev;
        logic [CODE_W-1:0]   code0;
        logic [CODE_W-1:0]   code1;
        logic [CODE_W-1:0]   code2;
        logic                codon_ok;
        logic [POS_W-1:0]    pos;
    } pileup_word_t;

    typedef struct packed {
        logic [OUT_W-1:0]          pos;
        logic [GRP_W-1:0]          grp;
        logic [3:0][OUT_W-1:0]     cnt;
        logic                      last;
    } column_group_t;

    // typed == 1: an advance whose column is written out by hand (codons all zero)
    typedef struct {
        pileup_word_t          w;
        bit                    typed;
        logic [OUT_W-1:0]      pos;
        logic [3:0][OUT_W-1:0] fwd;
        logic [3:0][OUT_W-1:0] rev;
        logic [OUT_W-1:0]      gap;
    } table_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           command;
    logic [OFS_W-1:0]     offset;
    logic                 reverse_strand;
    logic [CODE_W-1:0]    base_code;
    logic [CODE_W-1:0]    next_code_one;
    logic [CODE_W-1:0]    next_code_two;
    logic                 codon_allowed;
    logic [POS_W-1:0]     new_position;
    logic                 out_valid;
    logic                 out_ready;
    logic [OUT_W-1:0]     column_position;
    logic [GRP_W-1:0]     group;
    logic [OUT_W-1:0]     count_zero;
    logic [OUT_W-1:0]     count_one;
    logic [OUT_W-1:0]     count_two;
    logic [OUT_W-1:0]     count_three;
    logic                 last;

    pileup_window_counter DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .offset          (offset),
        .reverse_strand  (reverse_strand),
        .base_code       (base_code),
        .next_code_one   (next_code_one),
        .next_code_two   (next_code_two),
        .codon_allowed   (codon_allowed),
        .new_position    (new_position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .column_position (column_position),
        .group           (group),
        .count_zero      (count_zero),
        .count_one       (count_one),
        .count_two       (count_two),
        .count_three     (count_three),
        .last            (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // column predictor state
    logic [COUNT_BITS-1:0] fwd_cnt   [WINDOW][4];
    logic [COUNT_BITS-1:0] rev_cnt   [WINDOW][4];
    logic [COUNT_BITS-1:0] gap_cnt   [WINDOW];
    logic [COUNT_BITS-1:0] codon_cnt [WINDOW][CODON_SLOTS];
    int                    head_col;
    logic [POS_W-1:0]      head_pos;

    column_group_t pending_groups[$];
    table_row_t    directed_rows[$];
    int            mismatch_count = 0;
    int            groups_seen    = 0;
    bit            calm           = 1'b0;

    function automatic int base_lane(input logic [CODE_W-1:0] code);
        case (code)
            4'h1:    return 0;
            4'h2:    return 1;
            4'h4:    return 2;
            4'h8:    return 3;
            default: return -1;
        endcase
    endfunction

    function automatic logic [COUNT_BITS-1:0] bumped(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic pileup_word_t make_word(input cmd_t cmd, input int ofs, input bit rev,
                                               input int c0, input int c1, input int c2,
                                               input bit ok, input logic [POS_W-1:0] pos);
        pileup_word_t w;
        w.cmd      = cmd;
        w.ofs      = OFS_W'(ofs);
        w.rev      = rev;
        w.code0    = CODE_W'(c0);
        w.code1    = CODE_W'(c1);
        w.code2    = CODE_W'(c2);
        w.codon_ok = ok;
        w.pos      = pos;
        return w;
    endfunction

    // mostly one of A/C/G/T, sometimes any code
    function automatic logic [CODE_W-1:0] rand_code();
        if ($urandom_range(99) < 85)
            return CODE_W'(1) << $urandom_range(3);
        return CODE_W'($urandom_range(15));
    endfunction

    function automatic pileup_word_t noise_word();
        pileup_word_t w;
        w = pileup_word_t'({$urandom, $urandom});
        return w;
    endfunction

    task automatic add_row(input pileup_word_t w);
        table_row_t r;
        r.w     = w;
        r.typed = 1'b0;
        r.pos   = '0;
        r.fwd   = '0;
        r.rev   = '0;
        r.gap   = '0;
        directed_rows.push_back(r);
    endtask

    task automatic add_typed(input logic [OUT_W-1:0] pos, input logic [3:0][OUT_W-1:0] fwd,
                             input logic [3:0][OUT_W-1:0] rev, input logic [OUT_W-1:0] gap);
        table_row_t r;
        r.w     = make_word(CMD_ADVANCE, 0, 1'b0, 0, 0, 0, 1'b0, '0);
        r.typed = 1'b1;
        r.pos   = pos;
        r.fwd   = fwd;
        r.rev   = rev;
        r.gap   = gap;
        directed_rows.push_back(r);
    endtask

    // Apply one accepted word to the predictor; an advance queues its 19 groups if asked.
    task automatic count_word(input pileup_word_t w, input bit record);
        int            b0;
        int            b1;
        int            b2;
        int            col;
        int            grp;
        int            k;
        column_group_t g;
        b0  = base_lane(w.code0);
        b1  = base_lane(w.code1);
        b2  = base_lane(w.code2);
        col = (head_col + int'(w.ofs)) % WINDOW;
        case (w.cmd)
            CMD_BASE:
            begin
                if (b0 >= 0)
                begin
                    if (w.rev)
                        rev_cnt[col][b0] = bumped(rev_cnt[col][b0]);
                    else
                        fwd_cnt[col][b0] = bumped(fwd_cnt[col][b0]);
                    if (w.codon_ok && b1 >= 0 && b2 >= 0)
                        codon_cnt[col][b0 * 16 + b1 * 4 + b2] =
                            bumped(codon_cnt[col][b0 * 16 + b1 * 4 + b2]);
                end
            end
            CMD_GAP:
                gap_cnt[col] = bumped(gap_cnt[col]);
            CMD_SETPOS:
                head_pos = w.pos;
            default:
            begin
                col = head_col;
                for (grp = 0; grp < COLUMN_GROUPS; grp++)
                begin
                    g.pos  = OUT_W'(head_pos) + 1'b1;
                    g.grp  = GRP_W'(grp);
                    g.cnt  = '0;
                    g.last = (grp == COLUMN_GROUPS - 1);
                    for (k = 0; k < 4; k++)
                    begin
                        if (grp == 0)
                            g.cnt[k] = OUT_W'(fwd_cnt[col][k]);
                        else if (grp == 1)
                            g.cnt[k] = OUT_W'(rev_cnt[col][k]);
                        else if (grp >= int'(GRP_FIRST_CODON))
                            g.cnt[k] = OUT_W'(codon_cnt[col][(grp - int'(GRP_FIRST_CODON)) * 4 + k]);
                    end
                    if (grp == GAP_GROUP)
                        g.cnt[0] = OUT_W'(gap_cnt[col]);
                    if (record)
                        pending_groups.push_back(g);
                end
                for (k = 0; k < 4; k++)
                begin
                    fwd_cnt[col][k] = '0;
                    rev_cnt[col][k] = '0;
                end
                for (k = 0; k < CODON_SLOTS; k++)
                    codon_cnt[col][k] = '0;
                gap_cnt[col] = '0;
                head_col = (col + 1) % WINDOW;
                head_pos = head_pos + 1'b1;
            end
        endcase
    endtask

    task automatic queue_typed_column(input table_row_t r);
        int            grp;
        column_group_t g;
        for (grp = 0; grp < COLUMN_GROUPS; grp++)
        begin
            g.pos  = r.pos;
            g.grp  = GRP_W'(grp);
            g.cnt  = (grp == 0) ? r.fwd : (grp == 1) ? r.rev : '0;
            g.last = (grp == COLUMN_GROUPS - 1);
            if (grp == GAP_GROUP)
                g.cnt[0] = r.gap;
            pending_groups.push_back(g);
        end
    endtask

    // Offer one word, with random idle cycles ahead of it; returns just after acceptance.
    task automatic send_row(input table_row_t r);
        while (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= r.w.cmd;
        offset         <= r.w.ofs;
        reverse_strand <= r.w.rev;
        base_code      <= r.w.code0;
        next_code_one  <= r.w.code1;
        next_code_two  <= r.w.code2;
        codon_allowed  <= r.w.codon_ok;
        new_position   <= r.w.pos;
        do
            @(negedge clk);
        while (!in_ready);
        if (r.typed)
            queue_typed_column(r);
        count_word(r.w, !r.typed);
        @(posedge clk);
    endtask

    task automatic send_word(input pileup_word_t w);
        table_row_t r;
        r.w     = w;
        r.typed = 1'b0;
        r.pos   = '0;
        r.fwd   = '0;
        r.rev   = '0;
        r.gap   = '0;
        send_row(r);
    endtask

    task automatic note_mismatch(input string what, input logic [OUT_W-1:0] expd,
                                 input logic [OUT_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, expd, got);
    endtask

    // score output words against the oldest pending group
    always @(negedge clk)
    begin
        column_group_t e;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            groups_seen++;
            if (pending_groups.size() == 0)
            begin
                note_mismatch("unexpected word, group", '0, OUT_W'(group));
            end
            else
            begin
                e = pending_groups.pop_front();
                if (column_position !== e.pos)
                    note_mismatch("column_position", e.pos, column_position);
                if (group !== e.grp)
                    note_mismatch("group", OUT_W'(e.grp), OUT_W'(group));
                if (count_zero !== e.cnt[0])
                    note_mismatch("count_zero", e.cnt[0], count_zero);
                if (count_one !== e.cnt[1])
                    note_mismatch("count_one", e.cnt[1], count_one);
                if (count_two !== e.cnt[2])
                    note_mismatch("count_two", e.cnt[2], count_two);
                if (count_three !== e.cnt[3])
                    note_mismatch("count_three", e.cnt[3], count_three);
                if (last !== e.last)
                    note_mismatch("last", OUT_W'(e.last), OUT_W'(last));
            end
        end
    end

    // output side: random stalls plus one long hold-off once two columns are out
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && groups_seen >= 2 * COLUMN_GROUPS)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 7);
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int                rand_words;
        int                i;
        int                k;
        int                run_len;
        int                ofs;
        bit                strand;
        int                pick;
        logic [CODE_W-1:0] seq [16];
        pileup_word_t      w;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        command        <= CMD_ADVANCE;
        offset         <= '0;
        reverse_strand <= 1'b0;
        base_code      <= '0;
        next_code_one  <= '0;
        next_code_two  <= '0;
        codon_allowed  <= 1'b0;
        new_position   <= '0;

        for (i = 0; i < WINDOW; i++)
        begin
            for (k = 0; k < 4; k++)
            begin
                fwd_cnt[i][k] = '0;
                rev_cnt[i][k] = '0;
            end
            for (k = 0; k < CODON_SLOTS; k++)
                codon_cnt[i][k] = '0;
            gap_cnt[i] = '0;
        end
        head_col = 0;
        head_pos = '0;

        // directed table
        add_typed(32'd1, '0, '0, '0);                          // empty column after reset
        add_row(make_word(CMD_SETPOS, 0, 1'b0, 0, 0, 0, 1'b0, 31'h7FFF_FFFF));
        add_row(make_word(CMD_BASE, 0, 1'b0, 4'h1, 4'h2, 4'h4, 1'b0, '0));
        add_row(make_word(CMD_BASE, 0, 1'b1, 4'h8, 4'h2, 4'h3, 1'b1, '0)); // ambiguous next
        add_row(make_word(CMD_BASE, 0, 1'b0, 4'h0, 4'h1, 4'h1, 1'b1, '0)); // ambiguous base
        add_row(make_word(CMD_BASE, 0, 1'b1, 4'hF, 4'h1, 4'h1, 1'b1, '0));
        add_row(make_word(CMD_GAP, 0, 1'b1, 4'hF, 4'hF, 4'hF, 1'b1, 31'h7FFF_FFFF));
        add_typed(32'h8000_0000, {32'd0, 32'd0, 32'd0, 32'd1},
                  {32'd1, 32'd0, 32'd0, 32'd0}, 32'd1);         // largest position
        add_row(make_word(CMD_BASE, 1023, 1'b0, 4'h4, 4'h8, 4'h8, 1'b1, '0)); // wraps
        add_row(make_word(CMD_BASE, 1023, 1'b1, 4'h2, 4'h1, 4'h1, 1'b1, '0));
        add_row(make_word(CMD_GAP, 1023, 1'b0, 0, 0, 0, 1'b0, '0));
        add_row(make_word(CMD_BASE, 0, 1'b0, 4'h8, 4'h8, 4'h8, 1'b1, '0));  // last codon
        add_row(make_word(CMD_BASE, 0, 1'b0, 4'h1, 4'h1, 4'h1, 1'b1, '0));  // first codon
        add_row(make_word(CMD_BASE, 0, 1'b0, 4'h1, 4'hF, 4'h1, 1'b1, '0));
        add_row(make_word(CMD_BASE, 0, 1'b1, 4'h4, 4'h4, 4'h2, 1'b1, '0));
        add_row(make_word(CMD_BASE, 5, 1'b0, 4'h2, 4'h8, 4'h0, 1'b1, '0));
        add_row(make_word(CMD_ADVANCE, 1023, 1'b1, 4'hF, 4'hF, 4'hF, 1'b1, 31'h7FFF_FFFF));
        add_typed(32'd2, '0, '0, '0);                           // position wrapped past max
        add_row(make_word(CMD_SETPOS, 1023, 1'b1, 4'hF, 4'hF, 4'hF, 1'b1, 31'd12345));
        add_row(make_word(CMD_GAP, 2, 1'b0, 4'h1, 4'h2, 4'h4, 1'b0, 31'h5555_5555));
        add_row(make_word(CMD_ADVANCE, 0, 1'b0, 0, 0, 0, 1'b0, '0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_row(directed_rows[i]);

        // read-like runs with random content, mixed with advances, repositions and noise
        rand_words = 0;
        while (rand_words < RANDOM_WORDS)
        begin
            calm = (rand_words >= 80 && rand_words < 140);
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                run_len = $urandom_range(3, 12);
                strand  = $urandom_range(1);
                ofs     = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(24);
                for (i = 0; i < run_len + 2; i++)
                    seq[i] = rand_code();
                for (i = 0; i < run_len; i++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        send_word(make_word(CMD_GAP, ofs, strand, $urandom_range(15),
                                            $urandom_range(15), $urandom_range(15),
                                            $urandom_range(1), POS_W'($urandom)));
                        ofs++;
                        rand_words++;
                    end
                    w = noise_word();
                    w.cmd      = CMD_BASE;
                    w.ofs      = OFS_W'(ofs);
                    w.rev      = strand;
                    w.code0    = seq[i];
                    w.code1    = seq[i + 1];
                    w.code2    = seq[i + 2];
                    w.codon_ok = (run_len - i >= 3);
                    send_word(w);
                    ofs++;
                    rand_words++;
                end
            end
            else if (pick < 82)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    w = noise_word();
                    w.cmd = CMD_ADVANCE;
                    send_word(w);
                    rand_words++;
                end
            end
            else if (pick < 90)
            begin
                w = noise_word();
                w.cmd = CMD_SETPOS;
                if ($urandom_range(3) == 0)
                    w.pos = 31'h7FFF_FFFF - POS_W'($urandom_range(3));
                send_word(w);
                rand_words++;
            end
            else
            begin
                send_word(noise_word());
                rand_words++;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_groups.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (mismatch_count == 0 && pending_groups.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
